// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the absorbing boundary block.
// Define NO_ASSERTIONS to compile every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset
`define SOB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included
`define SOB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SOB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SOB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/sob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_pkg
// Widths, codes, history row layout and saturation for the second-order
// absorbing boundary block.
// ----------------------------------------------------------------------------
package sob_pkg;

  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 32;
  localparam int SIDE_W    = 2;
  localparam int POS_W     = 10;
  localparam int ADDR_W    = SIDE_W + POS_W;
  localparam int HIST_ROWS = 1 << ADDR_W;
  localparam int CFG_IDX_W = 2;

  // Edge lengths of the grid
  localparam int MAX_X = 1024;
  localparam int MAX_Y = 1024;
  localparam int LEN_W = 17;

  // Sum widths: exact sums of fields, partial products and their totals
  localparam int SUM_W  = FIELD_W + 2;
  localparam int PHI_W  = SUM_W + COEF_W / 2;
  localparam int PLO_W  = SUM_W + COEF_W / 2 + 1;
  localparam int HSUM_W = PHI_W + 2;
  localparam int LSUM_W = PLO_W + 2;
  localparam int TOT_W  = HSUM_W + COEF_W / 2;
  localparam int ACC_W  = TOT_W - 28;
  localparam int DIFF_W = ACC_W + 1;

  // Side codes
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO  = 2'd2;

  typedef logic signed [FIELD_W-1:0] field_t;

  // One history row per boundary cell: prev is t-1, old is t-2
  typedef struct packed {
    field_t far_old;
    field_t far_prev;
    field_t near_old;
    field_t near_prev;
    field_t edge_old;
    field_t edge_prev;
  } hist_row_t;

  localparam int ROW_W = $bits(hist_row_t);

  // Payload carried alongside the arithmetic
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    field_t            d1;
    field_t            d2;
    field_t            h_edge_prev;
    field_t            h_near_prev;
    field_t            h_far_prev;
    field_t            h_far_old;
  } carry_t;

  function automatic field_t sat_field(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = DIFF_W'(32'sh7fff_ffff);
    lo = DIFF_W'(32'sh8000_0000);
    if (x > hi) begin
      return 32'sh7fff_ffff;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/second_order_absorbing_boundary.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_absorbing_boundary
// Second-order Mur edge update for a 2D grid, one boundary cell per transfer,
// with per-cell history of the last two time steps held in RAM.
// ----------------------------------------------------------------------------
//  channel | signals                                         | transfer
//  --------+-------------------------------------------------+-----------------
//  in      | side_i position_i near_value_i far_value_i      | in_valid_i & in_ready_o
//  out     | edge_value_o                                    | out_valid_o & out_ready_i
//  cfg     | cfg_index_i cfg_data_i                          | cfg_we_i
//
//  One cell per cycle while no hazard or back-pressure holds the input; the
//  stages are RAM read, field sums, products, partial sums, rounding, saturate.
//  A cell whose previous update is still in the pipe waits until that update is
//  written back, a wait that back-pressure lengthens; the history RAM is the only copy.
//  After reset a clearing pass zeroes the 4096 history rows, one per cycle;
//  no input transfer is taken until it ends. Config writes are taken always.
//  Each stage holds under back-pressure and advances into an empty slot.
// ----------------------------------------------------------------------------
module second_order_absorbing_boundary (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sob_pkg::SIDE_W-1:0]       side_i,
  input  logic [sob_pkg::POS_W-1:0]        position_i,
  input  logic signed [sob_pkg::FIELD_W-1:0] near_value_i,
  input  logic signed [sob_pkg::FIELD_W-1:0] far_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sob_pkg::FIELD_W-1:0] edge_value_o,
  input  logic                             cfg_we_i,
  input  logic [sob_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sob_pkg::COEF_W-1:0]       cfg_data_i
);

  import sob_pkg::*;

  `include "assert_macros.svh"

  // Configuration
  logic signed [COEF_W-1:0] coef_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= '0;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COEF_ZERO: coef_q[0] <= cfg_data_i;
        CFG_COEF_ONE:  coef_q[1] <= cfg_data_i;
        CFG_COEF_TWO:  coef_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage advances when its successor is empty or advancing
  logic en1, en2, en3, en4, en5, en6;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;

  assign en6 = !out_valid_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  // Clearing pass
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ADDR_W'(HIST_ROWS - 1)) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  // Input, hazard check
  logic [ADDR_W-1:0] in_addr;
  logic              in_range;
  logic              hazard;
  logic              in_accept;
  logic [ADDR_W-1:0] a1_q;
  logic              r1_q;
  field_t            d1_1_q, d2_1_q;
  carry_t            c2_q, c3_q, c4_q, c5_q;

  assign in_addr = {side_i, position_i};

  always_comb begin
    if (side_i == SIDE_LEFT || side_i == SIDE_RIGHT) begin
      in_range = LEN_W'(position_i) < LEN_W'(MAX_Y);
    end else begin
      in_range = LEN_W'(position_i) < LEN_W'(MAX_X);
    end
  end

  // Hold a cell back while an update of the same cell is not yet written
  assign hazard = (v1_q && a1_q == in_addr) || (v2_q && c2_q.addr == in_addr) ||
                  (v3_q && c3_q.addr == in_addr) || (v4_q && c4_q.addr == in_addr) ||
                  (v5_q && c5_q.addr == in_addr);

  assign in_ready_o = en1 && clr_done_q && !hazard;
  assign in_accept  = in_valid_i && in_ready_o;

  // History RAM
  logic              hist_we;
  logic              hist_wr_pipe;
  logic [ADDR_W-1:0] hist_waddr;
  hist_row_t         hist_wdata;
  hist_row_t         new_row;
  hist_row_t         row1;
  logic [ROW_W-1:0]  rdata;

  assign hist_wr_pipe = v5_q && en6 && c5_q.in_range;
  assign hist_we      = !clr_done_q || hist_wr_pipe;
  assign hist_waddr   = clr_done_q ? c5_q.addr : clr_cnt_q;
  assign hist_wdata   = clr_done_q ? new_row : '0;
  assign row1         = hist_row_t'(rdata);

  sob_ram #(
    .WIDTH (ROW_W),
    .DEPTH (HIST_ROWS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (en1),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Stage 1: RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a1_q   <= in_addr;
      r1_q   <= in_range;
      d1_1_q <= near_value_i;
      d2_1_q <= far_value_i;
    end
  end

  // Stage 2: exact field sums
  logic signed [SUM_W-1:0] s_d [3];
  logic signed [SUM_W-1:0] s_q [3];
  carry_t                  c2_d;

  always_comb begin
    s_d[0] = SUM_W'(d2_1_q) + SUM_W'(row1.edge_old);
    s_d[1] = SUM_W'(row1.edge_prev) + SUM_W'(row1.far_prev) - SUM_W'(d1_1_q)
             - SUM_W'(row1.near_old);
    s_d[2] = SUM_W'(row1.near_prev);
    c2_d.addr        = a1_q;
    c2_d.in_range    = r1_q;
    c2_d.d1          = d1_1_q;
    c2_d.d2          = d2_1_q;
    c2_d.h_edge_prev = row1.edge_prev;
    c2_d.h_near_prev = row1.near_prev;
    c2_d.h_far_prev  = row1.far_prev;
    c2_d.h_far_old   = row1.far_old;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s_q  <= s_d;
      c2_q <= c2_d;
    end
  end

  // Stage 3: partial products, coefficient split into signed high and
  // unsigned low halves
  logic signed [PHI_W-1:0] phi_d [3];
  logic signed [PLO_W-1:0] plo_d [3];
  logic signed [PHI_W-1:0] phi_q [3];
  logic signed [PLO_W-1:0] plo_q [3];

  always_comb begin
    logic signed [PHI_W-1:0] sh, ch;
    logic signed [PLO_W-1:0] sl, cl;
    for (int k = 0; k < 3; k++) begin
      sh = PHI_W'(s_q[k]);
      ch = PHI_W'($signed(coef_q[k][COEF_W-1:COEF_W/2]));
      sl = PLO_W'(s_q[k]);
      cl = $signed({{(PLO_W - COEF_W/2){1'b0}}, coef_q[k][COEF_W/2-1:0]});
      phi_d[k] = sh * ch;
      plo_d[k] = sl * cl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      phi_q <= phi_d;
      plo_q <= plo_d;
      c3_q  <= c2_q;
    end
  end

  // Stage 4: sums of the high and low products
  logic signed [HSUM_W-1:0] hsum_d, hsum_q;
  logic signed [LSUM_W-1:0] lsum_d, lsum_q;

  assign hsum_d = HSUM_W'(phi_q[0]) + HSUM_W'(phi_q[1]) + HSUM_W'(phi_q[2]);
  assign lsum_d = LSUM_W'(plo_q[0]) + LSUM_W'(plo_q[1]) + LSUM_W'(plo_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hsum_q <= hsum_d;
      lsum_q <= lsum_d;
      c4_q   <= c3_q;
    end
  end

  // Stage 5: combine and round Q.44 to Q16.16, half up
  logic signed [TOT_W-1:0] total;
  logic signed [ACC_W-1:0] acc_d, acc_q;

  assign total = {hsum_q, {(COEF_W/2){1'b0}}} + TOT_W'(lsum_q) + TOT_W'(1 << 27);
  assign acc_d = total[TOT_W-1:28];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      acc_q <= acc_d;
      c5_q  <= c4_q;
    end
  end

  // Stage 6: subtract far t-2, saturate, write back in-range cells and present
  logic signed [DIFF_W-1:0] diff;
  field_t                   res;
  field_t                   edge_q;

  assign diff = DIFF_W'(acc_q) - DIFF_W'(c5_q.h_far_old);
  assign res  = c5_q.in_range ? sat_field(diff) : '0;

  always_comb begin
    new_row.edge_prev = res;
    new_row.edge_old  = c5_q.h_edge_prev;
    new_row.near_prev = c5_q.d1;
    new_row.near_old  = c5_q.h_near_prev;
    new_row.far_prev  = c5_q.d2;
    new_row.far_old   = c5_q.h_far_prev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en6) begin
      out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      edge_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = edge_q;

  `SOB_ASSERT_ALWAYS(a_no_input_while_clearing, clk_i, in_ready_o |-> clr_done_q, "input taken during clearing pass")
  `SOB_ASSERT(a_no_wb_while_clearing, clk_i, rst_ni, hist_wr_pipe |-> clr_done_q, "write-back collides with clearing pass")
  `SOB_ASSERT(a_no_stale_read, clk_i, rst_ni, ($past(hist_wr_pipe) && $past(in_accept) && v1_q) |-> (a1_q != $past(hist_waddr)), "cell read in the cycle of its own write-back")
  `SOB_ASSERT(a_out_from_stage5, clk_i, rst_ni, $rose(out_valid_o) |-> $past(v5_q), "result appears without an item in the rounding stage")

endmodule

// ===== rtl/sob_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/sob_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_checker
// Watches the cell, edge value and coefficient ports of the absorbing
// boundary block. It keeps its own per-cell history and coefficients, works
// out each new edge value and compares it with what leaves the block.
// ----------------------------------------------------------------------------
module sob_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [sob_pkg::SIDE_W-1:0]    side_i,
  input  logic [sob_pkg::POS_W-1:0]     position_i,
  input  sob_pkg::field_t               near_value_i,
  input  sob_pkg::field_t               far_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  sob_pkg::field_t               edge_value_i,
  input  logic                          cfg_we_i,
  input  logic [sob_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sob_pkg::COEF_W-1:0]    cfg_data_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            compared_o,
  output int                            saturated_o
);

  import sob_pkg::*;

  typedef logic signed [79:0] wide_t;

  localparam wide_t FIELD_MAX = 80'sd2147483647;
  localparam wide_t FIELD_MIN = -80'sd2147483648;
  // half of one Q16.16 step, seen from the Q.44 product sum
  localparam wide_t HALF_LSB  = 80'sd134217728;

  logic signed [COEF_W-1:0] coef_zero;
  logic signed [COEF_W-1:0] coef_one;
  logic signed [COEF_W-1:0] coef_two;
  hist_row_t                cell_hist [HIST_ROWS];
  field_t                   edge_due [$];

  int                       errors;
  int                       compared;
  int                       saturated;
  int                       edge_len;
  logic [ADDR_W-1:0]        row;
  hist_row_t                h;
  field_t                   next_val;
  field_t                   due;
  bit                       clipped;

  function automatic field_t mur_edge(input hist_row_t hr, input field_t d1, input field_t d2,
                                      output bit sat);
    field_t e_prev, e_old, n_prev, n_old, f_prev, f_old;
    wide_t  c0, c1, c2, s0, s1, s2, acc;
    e_prev = hr.edge_prev;
    e_old  = hr.edge_old;
    n_prev = hr.near_prev;
    n_old  = hr.near_old;
    f_prev = hr.far_prev;
    f_old  = hr.far_old;
    c0 = coef_zero;
    c1 = coef_one;
    c2 = coef_two;
    s0 = d2 + e_old;
    s1 = e_prev + f_prev - d1 - n_old;
    s2 = n_prev;
    // round half up to Q16.16, then take off the far value from two steps back
    acc = (c0 * s0 + c1 * s1 + c2 * s2 + HALF_LSB) >>> 28;
    acc = acc - f_old;
    sat = 1'b1;
    if (acc > FIELD_MAX) return 32'sh7fff_ffff;
    if (acc < FIELD_MIN) return 32'sh8000_0000;
    sat = 1'b0;
    return acc[FIELD_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_zero = '0;
      coef_one  = '0;
      coef_two  = '0;
      for (int r = 0; r < HIST_ROWS; r++) cell_hist[r] = '0;
      edge_due.delete();
      errors    = 0;
      compared  = 0;
      saturated = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COEF_ZERO: coef_zero = cfg_data_i;
          CFG_COEF_ONE:  coef_one  = cfg_data_i;
          CFG_COEF_TWO:  coef_two  = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (edge_due.size() == 0) begin
          errors++;
          $display("%0t: edge value %0d transferred with no result due", $time, edge_value_i);
        end else begin
          due = edge_due.pop_front();
          compared++;
          if (edge_value_i !== due) begin
            errors++;
            $display("%0t: edge value mismatch, expected %0d, got %0d",
                     $time, due, edge_value_i);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        row      = {side_i, position_i};
        edge_len = (side_i == SIDE_LEFT || side_i == SIDE_RIGHT) ? MAX_Y : MAX_X;
        if (position_i >= edge_len) begin
          // no cell here: zero out, history untouched
          edge_due.push_back('0);
        end else begin
          h        = cell_hist[row];
          next_val = mur_edge(h, near_value_i, far_value_i, clipped);
          if (clipped) saturated++;
          cell_hist[row] = '{far_old:   h.far_prev,  far_prev:  far_value_i,
                             near_old:  h.near_prev, near_prev: near_value_i,
                             edge_old:  h.edge_prev, edge_prev: next_val};
          edge_due.push_back(next_val);
        end
      end
    end
    errors_o    <= errors;
    pending_o   <= edge_due.size();
    compared_o  <= compared;
    saturated_o <= saturated;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives boundary cells and coefficient sets into the second-order absorbing
// boundary block: a short directed run on rounding, saturation and repeated
// cells, then time-stepped sweeps over small groups of cells with noise,
// random pacing on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import sob_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_CELLS   = 64;
  localparam int FLOOD_PHASE   = 2;
  localparam int FLOOD_CELLS   = 48;
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 12;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_e;
  typedef enum int {MIX_MUR, MIX_FULL, MIX_EXTREME, MIX_ZERO} coef_mix_e;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [SIDE_W-1:0]    side        = '0;
  logic [POS_W-1:0]     position    = '0;
  field_t               near_value  = '0;
  field_t               far_value   = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  field_t               edge_value;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [COEF_W-1:0]    cfg_data    = '0;

  int fail_count;
  int pending_cells;
  int compared;
  int saturated;

  int burst_left = 0;
  bit no_gaps    = 1'b0;
  bit flood      = 1'b0;
  int cells_sent = 0;
  int settings   = 0;

  always #(HALF_PERIOD) clk = ~clk;

  second_order_absorbing_boundary dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .side_i       (side),
    .position_i   (position),
    .near_value_i (near_value),
    .far_value_i  (far_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .edge_value_o (edge_value),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  sob_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .side_i       (side),
    .position_i   (position),
    .near_value_i (near_value),
    .far_value_i  (far_value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .edge_value_i (edge_value),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (fail_count),
    .pending_o    (pending_cells),
    .compared_o   (compared),
    .saturated_o  (saturated)
  );

  function automatic field_t pick_field();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return r[0] ? -32'sd1 : 32'sd0;
      3, 4, 5, 6: return {{12{r[19]}}, r[19:0]};
      7, 8:    return {{4{r[27]}}, r[27:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_extreme_coef();
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'h1000_0000;
    endcase
  endfunction

  // Random bursts and gaps between transfers, unless a flood is running
  task automatic pace();
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 5)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_cell(input logic [SIDE_W-1:0] s, input logic [POS_W-1:0] p,
                           input field_t nv, input field_t fv);
    in_valid   <= 1'b1;
    side       <= s;
    position   <= p;
    near_value <= nv;
    far_value  <= fv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
    pace();
  endtask

  // Drop valid and wait for every outstanding edge value
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells != 0) @(posedge clk);
  endtask

  task automatic write_coefs(input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
                             input logic [COEF_W-1:0] c2);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COEF_ZERO;
    cfg_data  <= c0;
    @(posedge clk);
    cfg_index <= CFG_COEF_ONE;
    cfg_data  <= c1;
    @(posedge clk);
    cfg_index <= CFG_COEF_TWO;
    cfg_data  <= c2;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  task automatic load_coefs(input coef_mix_e mix);
    logic [COEF_W-1:0] c0, c1, c2;
    case (mix)
      MIX_MUR: begin
        // shaped like real Mur coefficients: c0 zero to minus one, c1 one to two, c2 one half to three
        c0 = $urandom_range(0, 32'h1000_0000);
        c0 = -c0;
        c1 = $urandom_range(32'h1000_0000, 32'h2000_0000);
        c2 = $urandom_range(32'h0800_0000, 32'h3000_0000);
      end
      MIX_FULL: begin
        c0 = $urandom;
        c1 = $urandom;
        c2 = $urandom;
      end
      MIX_EXTREME: begin
        c0 = pick_extreme_coef();
        c1 = pick_extreme_coef();
        c2 = pick_extreme_coef();
      end
      default: begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
      end
    endcase
    write_coefs(c0, c1, c2);
  endtask

  // Sweep a small group of cells once per time step, with stray cells mixed in
  task automatic run_time_steps(input int quota);
    logic [ADDR_W-1:0] group [8];
    int                n_cells;
    int                done;
    n_cells = $urandom_range(1, 8);
    for (int k = 0; k < n_cells; k++) group[k] = {SIDE_W'($urandom), pick_pos()};
    done = 0;
    while (done < quota) begin
      for (int k = 0; k < n_cells && done < quota; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_cell(SIDE_W'($urandom), POS_W'($urandom), pick_field(), pick_field());
          done++;
        end
        send_cell(group[k][ADDR_W-1:POS_W], group[k][POS_W-1:0], pick_field(), pick_field());
        done++;
        if ($urandom_range(0, 9) == 0) begin
          // same cell again straight away
          send_cell(group[k][ADDR_W-1:POS_W], group[k][POS_W-1:0], pick_field(), pick_field());
          done++;
        end
      end
    end
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int       seg_len;
    bit       held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (flood && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 2));
        seg_len = $urandom_range(4, 40);
        repeat (seg_len) begin
          case (mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
          if (flood && !held) break;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run stopped after %0d cycles", $time, cycles);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    coef_mix_e plan [RANDOM_PHASES];
    plan = '{MIX_MUR, MIX_FULL, MIX_MUR, MIX_EXTREME, MIX_ZERO};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ties at half a step round upwards, fresh cells so history is zero
    write_coefs(32'h0800_0000, '0, '0);
    send_cell(SIDE_LEFT, 10'd0, '0, -32'sd1);
    send_cell(SIDE_LEFT, 10'd1, '0, 32'sd1);
    send_cell(SIDE_LEFT, 10'd2, '0, 32'sd3);
    send_cell(SIDE_LEFT, 10'd3, '0, -32'sd3);

    // drive into saturation both ways, same cell back to back
    write_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_cell(SIDE_TOP, 10'd1023, 32'sh8000_0000, 32'sh7fff_ffff);
    send_cell(SIDE_TOP, 10'd1023, 32'sh7fff_ffff, 32'sh8000_0000);
    send_cell(SIDE_TOP, 10'd1023, 32'sh8000_0000, 32'sh8000_0000);
    send_cell(SIDE_RIGHT, 10'd0, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_cell(SIDE_RIGHT, 10'd0, '0, '0);

    write_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cell(SIDE_TOP, 10'd1023, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_cell(SIDE_TOP, 10'd1023, 32'sh8000_0000, 32'sh8000_0000);
    send_cell(SIDE_RIGHT, 10'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_cell(SIDE_BOTTOM, 10'd1023, 32'sh7fff_ffff, 32'sh8000_0000);

    // unit-sized coefficients of mixed sign on one cell over four steps
    write_coefs(32'h1000_0000, 32'hf000_0000, 32'h2000_0000);
    send_cell(SIDE_BOTTOM, 10'd512, 32'sh0001_0000, 32'sh0002_0000);
    send_cell(SIDE_BOTTOM, 10'd512, -32'sh0003_8000, 32'sh0000_8000);
    send_cell(SIDE_BOTTOM, 10'd512, 32'sh0010_0001, -32'sh0007_ffff);
    send_cell(SIDE_BOTTOM, 10'd512, '0, '0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_coefs(plan[ph]);
      if (ph == FLOOD_PHASE) begin
        // offer cells without pause while the output side holds off
        no_gaps = 1'b1;
        flood  <= 1'b1;
        run_time_steps(FLOOD_CELLS);
        no_gaps = 1'b0;
      end
      run_time_steps(PHASE_CELLS);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d cells sent under %0d coefficient sets, %0d edge values compared",
             cells_sent, settings, compared);
    $display("Summary: %0d edge values clipped at the field limits", saturated);
    if (fail_count == 0 && pending_cells == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures, %0d edge values outstanding", fail_count, pending_cells);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
